// ===== design/dcis_pkg.sv =====
package dcis_pkg;

  // Access codes
  localparam logic [2:0] OP_RD_SYNC = 3'd0;
  localparam logic [2:0] OP_RD_CTRL = 3'd1;
  localparam logic [2:0] OP_RD_RECV = 3'd2;
  localparam logic [2:0] OP_WR_SYNC = 3'd3;
  localparam logic [2:0] OP_WR_CTRL = 3'd4;
  localparam logic [2:0] OP_SEND    = 3'd5;
  // Unassigned access codes: no effect
  localparam logic [2:0] OP_RSVD0   = 3'd6;
  localparam logic [2:0] OP_RSVD1   = 3'd7;

  // Bit positions in the sync register
  localparam int SYNC_REQ_BIT = 13;
  localparam int SYNC_EN_BIT  = 14;

  // Bit positions in the control register
  localparam int CTRL_SE_EN_BIT  = 2;
  localparam int CTRL_CLEAR_BIT  = 3;
  localparam int CTRL_RNE_EN_BIT = 10;
  localparam int CTRL_ERR_BIT    = 14;
  localparam int CTRL_FEN_BIT    = 15;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        side;
    logic [31:0] write_data;
    logic [15:0] write_mask;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_side;
    logic        irq_sync;
    logic        irq_send_empty;
    logic        irq_recv_nonempty;
  } out_item_t;

endpackage

// ===== design/dcis_ram.sv =====
module dcis_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic          wside,
  input  logic [AW-1:0] widx,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic          rside,
  input  logic [AW-1:0] ridx,
  output logic [31:0]   rdata
);

  logic [31:0] mem [0:1][0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wside][widx] <= wdata;
    end
  end

  // Pass a word being written in the same cycle straight to the read port.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (wside == rside) && (widx == ridx)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[rside][ridx];
      end
    end
  end

endmodule

// ===== design/dcis_ctrl.sv =====
module dcis_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  dcis_pkg::in_item_t   item,
  input  logic [31:0]          mem_rdata,
  output logic [1:0][AW-1:0]   head_ahead,
  output logic                 mem_we,
  output logic                 mem_wside,
  output logic [AW-1:0]        mem_widx,
  output logic [31:0]          mem_wdata,
  output dcis_pkg::out_item_t  result
);
  import dcis_pkg::*;

  localparam int SW = CW + 1;

  logic [1:0]          fen_r, fen_nxt;
  logic [1:0]          err_r, err_nxt;
  logic [1:0]          rne_r, rne_nxt;
  logic [1:0]          se_r, se_nxt;
  logic [1:0]          sen_r, sen_nxt;
  logic [1:0][3:0]     nib_r, nib_nxt;
  logic [1:0][CW-1:0]  cnt_r, cnt_nxt;
  logic [1:0][AW-1:0]  head_r, head_nxt;
  logic [1:0][31:0]    last_r, last_nxt;

  logic                s, o;
  logic [15:0]         val, wm;
  logic [SW-1:0]       tail_sum;
  logic [AW-1:0]       tail;
  logic [CW-1:0]       head_inc;
  logic [AW-1:0]       head_o_next;
  logic                full_s, full_o, empty_s, empty_o;
  logic                fen_new, rne_new, se_new;
  logic [CW-1:0]       cnt_after;
  logic                we_c;

  assign s   = item.side;
  assign o   = ~item.side;
  assign val = item.write_data[15:0];
  assign wm  = item.write_mask;

  // Tail slot of the sender's FIFO: head plus count, wrapped once.
  assign tail_sum = SW'(head_r[s]) + SW'(cnt_r[s]);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  // Head of the receive FIFO after one pop.
  assign head_inc    = CW'(head_r[o]) + CW'(1);
  assign head_o_next = (head_inc >= CW'(DEPTH)) ? '0 : AW'(head_inc);

  assign empty_s = (cnt_r[s] == '0);
  assign empty_o = (cnt_r[o] == '0);
  assign full_s  = (cnt_r[s] >= CW'(DEPTH));
  assign full_o  = (cnt_r[o] >= CW'(DEPTH));

  assign fen_new = wm[CTRL_FEN_BIT] ? val[CTRL_FEN_BIT] : fen_r[s];
  assign rne_new = wm[CTRL_RNE_EN_BIT] ? val[CTRL_RNE_EN_BIT] : rne_r[s];
  assign se_new  = wm[CTRL_SE_EN_BIT] ? val[CTRL_SE_EN_BIT] : se_r[s];
  assign cnt_after = val[CTRL_CLEAR_BIT] ? '0 : cnt_r[s];

  always_comb begin
    fen_nxt  = fen_r;
    err_nxt  = err_r;
    rne_nxt  = rne_r;
    se_nxt   = se_r;
    sen_nxt  = sen_r;
    nib_nxt  = nib_r;
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    last_nxt = last_r;
    we_c     = 1'b0;
    result   = '0;
    result.irq_side = s;
    unique case (item.opcode)
      OP_RD_SYNC: begin
        result.read_data = {17'b0, sen_r[s], 2'b0, nib_r[s], 4'b0, nib_r[o]};
      end
      OP_RD_CTRL: begin
        result.read_data = {16'b0, fen_r[s], err_r[s], 3'b0, rne_r[s], full_o, empty_o,
                            5'b0, se_r[s], full_s, empty_s};
      end
      OP_RD_RECV: begin
        result.irq_side = o;
        if (!empty_o) begin
          last_nxt[s]      = mem_rdata;
          result.read_data = mem_rdata;
          if (fen_r[s]) begin
            head_nxt[o] = head_o_next;
            cnt_nxt[o]  = cnt_r[o] - CW'(1);
            result.irq_send_empty = (cnt_r[o] == CW'(1)) && se_r[o];
          end
        end else begin
          err_nxt[s]       = 1'b1;
          result.read_data = last_r[s];
        end
      end
      OP_WR_SYNC: begin
        result.irq_side = o;
        if (wm[SYNC_EN_BIT]) begin
          sen_nxt[s] = val[SYNC_EN_BIT];
        end
        nib_nxt[s] = (nib_r[s] & ~wm[11:8]) | (val[11:8] & wm[11:8]);
        result.irq_sync = val[SYNC_REQ_BIT] && wm[SYNC_REQ_BIT] && sen_r[o];
      end
      OP_WR_CTRL: begin
        fen_nxt[s] = fen_new;
        rne_nxt[s] = rne_new;
        se_nxt[s]  = se_new;
        if (val[CTRL_CLEAR_BIT]) begin
          cnt_nxt[s]  = '0;
          head_nxt[s] = '0;
        end
        result.irq_send_empty = (val[CTRL_CLEAR_BIT] && se_new) ||
                                (!se_r[s] && se_new && (cnt_after == '0));
        result.irq_recv_nonempty = !rne_r[s] && rne_new && !empty_o;
        if (val[CTRL_ERR_BIT]) begin
          err_nxt[s] = 1'b0;
        end
      end
      OP_SEND: begin
        result.irq_side = o;
        if (fen_r[s]) begin
          if (!full_s) begin
            we_c       = 1'b1;
            cnt_nxt[s] = cnt_r[s] + CW'(1);
            result.irq_recv_nonempty = empty_s && rne_r[o];
          end else begin
            err_nxt[s] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_we     = fire && we_c;
  assign mem_wside  = s;
  assign mem_widx   = tail;
  assign mem_wdata  = item.write_data;
  assign head_ahead = fire ? head_nxt : head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fen_r  <= '0;
      err_r  <= '0;
      rne_r  <= '0;
      se_r   <= '0;
      sen_r  <= '0;
      nib_r  <= '0;
      cnt_r  <= '0;
      head_r <= '0;
      last_r <= '0;
    end else if (fire) begin
      fen_r  <= fen_nxt;
      err_r  <= err_nxt;
      rne_r  <= rne_nxt;
      se_r   <= se_nxt;
      sen_r  <= sen_nxt;
      nib_r  <= nib_nxt;
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
      last_r <= last_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CW'(DEPTH)) && (cnt_r[1] <= CW'(DEPTH)))
    else $error("fifo count beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(head_r[0]) < CW'(DEPTH)) && (CW'(head_r[1]) < CW'(DEPTH)))
    else $error("fifo head beyond depth");

  a_send_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.opcode == OP_SEND) && !item.side |=> cnt_r[0] >= $past(cnt_r[0]))
    else $error("send lowered own fifo count");

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !full_s && fen_r[s])
    else $error("fifo write while full or disabled");

endmodule

// ===== design/dual_cpu_ipc_sync_fifo_top.sv =====
// Two-processor mailbox: sync nibbles, FIFO control registers and a pair of
// send FIFOs, one per processor; each side pops the other side's FIFO.
// Input channel (in_valid/in_ready/in_data): one bus access per item, giving
// the access code, the accessing side, write data and a write mask.
// Result channel (out_valid/out_ready/out_data): one item per access with
// read data and one pulse per interrupt kind toward out_data.irq_side.
// An accepted access is held in the access register and its result is then
// registered in the result register. Throughput: one access per cycle unless
// out_ready stalls; the access register, the single pass of register update
// logic and the result register form the only path, and the FIFO word for a
// receive is fetched from the FIFO RAM as the access enters.
// Reset (rst_n low, synchronous): sync and control registers, FIFO counts and
// heads and the last received words clear; FIFO contents stay undefined and
// need no clearing pass, so an access can be taken right after reset.
// Stall: while out_ready is low the result holds in the output register, one
// further access is taken into the access register and then in_ready drops
// until the result is taken.
module dual_cpu_ipc_sync_fifo_top #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dcis_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dcis_pkg::out_item_t  out_data
);
  import dcis_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  // Access register
  logic      acc_valid_r, acc_valid_nxt;
  in_item_t  acc_r;
  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r;

  logic                advance;
  logic                take;
  out_item_t           result;
  logic [1:0][AW-1:0]  head_ahead;
  logic                mem_we;
  logic                mem_wside;
  logic [AW-1:0]       mem_widx;
  logic [31:0]         mem_wdata;
  logic [31:0]         mem_rdata;
  logic                rside;

  // Advance the held access when the result register is free or being emptied.
  assign advance  = acc_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !acc_valid_r || advance;
  assign take     = in_valid && in_ready;

  assign acc_valid_nxt = take ? 1'b1 : (advance ? 1'b0 : acc_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_valid_r <= acc_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  // Fetch the receive FIFO front for the incoming access, using the heads as
  // they stand after the access that leaves at the same edge.
  assign rside = ~in_data.side;

  dcis_ram #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .wside (mem_wside),
    .widx  (mem_widx),
    .wdata (mem_wdata),
    .re    (take),
    .rside (rside),
    .ridx  (head_ahead[rside]),
    .rdata (mem_rdata)
  );

  dcis_ctrl #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .item       (acc_r),
    .mem_rdata  (mem_rdata),
    .head_ahead (head_ahead),
    .mem_we     (mem_we),
    .mem_wside  (mem_wside),
    .mem_widx   (mem_widx),
    .mem_wdata  (mem_wdata),
    .result     (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input blocked with empty result register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> acc_valid_r && out_valid_r && !out_ready)
    else $error("input blocked without a stalled result");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced access produced no result");

endmodule

// ===== bench/ipc_mailbox_checker.sv =====
`timescale 1ns / 100ps

module ipc_mailbox_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  dcis_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dcis_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  results_outstanding
);
  import dcis_pkg::*;

  localparam int DEPTH = 16;

  // Mirror of the mailbox state
  logic [15:0] sync_reg  [2];
  logic [15:0] ctrl_reg  [2];
  logic [31:0] fifo_word [2][DEPTH];
  int unsigned fifo_cnt  [2];
  int unsigned fifo_head [2];
  logic [31:0] last_rx   [2];

  out_item_t expected_results[$];

  initial fail_count = 0;

  function automatic logic [15:0] ctrl_view(bit s);
    logic [15:0] v;
    v = ctrl_reg[s] & 16'hC404;
    if (fifo_cnt[s] == 0) v[0] = 1'b1;
    if (fifo_cnt[s] >= DEPTH) v[1] = 1'b1;
    if (fifo_cnt[!s] == 0) v[8] = 1'b1;
    if (fifo_cnt[!s] >= DEPTH) v[9] = 1'b1;
    return v;
  endfunction

  // Apply one access to the mirror and return the result it must produce.
  function automatic out_item_t mailbox_access(in_item_t a);
    bit          s;
    bit          o;
    logic [15:0] val;
    logic [15:0] wm;
    logic [15:0] m;
    logic [15:0] old;
    out_item_t   r;
    s   = a.side;
    o   = !a.side;
    val = a.write_data[15:0];
    wm  = a.write_mask;
    r   = '0;
    r.irq_side = s;
    case (a.opcode)
      OP_RD_SYNC: r.read_data = {16'h0, sync_reg[s] & 16'h4F0F};
      OP_RD_CTRL: r.read_data = {16'h0, ctrl_view(s)};
      OP_RD_RECV: begin
        r.irq_side = o;
        if (fifo_cnt[o] != 0) begin
          last_rx[s] = fifo_word[o][fifo_head[o]];
          if (ctrl_reg[s][CTRL_FEN_BIT]) begin
            fifo_head[o] = (fifo_head[o] + 1) % DEPTH;
            fifo_cnt[o]  = fifo_cnt[o] - 1;
            if (fifo_cnt[o] == 0 && ctrl_reg[o][CTRL_SE_EN_BIT]) r.irq_send_empty = 1'b1;
          end
        end else begin
          ctrl_reg[s][CTRL_ERR_BIT] = 1'b1;
        end
        r.read_data = last_rx[s];
      end
      OP_WR_SYNC: begin
        r.irq_side  = o;
        m           = wm & 16'h4F00;
        sync_reg[s] = (sync_reg[s] & ~m & 16'h4F0F) | (val & m);
        sync_reg[o] = (sync_reg[o] & 16'h4F00) | {12'h0, sync_reg[s][11:8]};
        if (val[SYNC_REQ_BIT] && wm[SYNC_REQ_BIT] && sync_reg[o][SYNC_EN_BIT])
          r.irq_sync = 1'b1;
      end
      OP_WR_CTRL: begin
        m           = wm & 16'h8404;
        old         = ctrl_reg[s];
        ctrl_reg[s] = ((old & ~m) | (val & m)) & 16'hC404;
        if (val[CTRL_CLEAR_BIT]) begin
          fifo_cnt[s]  = 0;
          fifo_head[s] = 0;
          if (ctrl_reg[s][CTRL_SE_EN_BIT]) r.irq_send_empty = 1'b1;
        end
        if (!old[CTRL_SE_EN_BIT] && ctrl_reg[s][CTRL_SE_EN_BIT] && fifo_cnt[s] == 0)
          r.irq_send_empty = 1'b1;
        if (!old[CTRL_RNE_EN_BIT] && ctrl_reg[s][CTRL_RNE_EN_BIT] && fifo_cnt[o] != 0)
          r.irq_recv_nonempty = 1'b1;
        if (val[CTRL_ERR_BIT]) ctrl_reg[s][CTRL_ERR_BIT] = 1'b0;
      end
      OP_SEND: begin
        r.irq_side = o;
        if (ctrl_reg[s][CTRL_FEN_BIT]) begin
          if (fifo_cnt[s] < DEPTH) begin
            fifo_word[s][(fifo_head[s] + fifo_cnt[s]) % DEPTH] = a.write_data;
            fifo_cnt[s] = fifo_cnt[s] + 1;
            if (fifo_cnt[s] == 1 && ctrl_reg[o][CTRL_RNE_EN_BIT]) r.irq_recv_nonempty = 1'b1;
          end else begin
            ctrl_reg[s][CTRL_ERR_BIT] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        sync_reg[s]  = '0;
        ctrl_reg[s]  = 16'h0101;
        fifo_cnt[s]  = 0;
        fifo_head[s] = 0;
        last_rx[s]   = '0;
      end
      expected_results.delete();
      results_outstanding <= 0;
    end else begin
      // Retire the result first: it always belongs to an earlier access.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none, got %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("read_data", want.read_data, out_data.read_data);
          compare_field("irq_side", 32'(want.irq_side), 32'(out_data.irq_side));
          compare_field("irq_sync", 32'(want.irq_sync), 32'(out_data.irq_sync));
          compare_field("irq_send_empty", 32'(want.irq_send_empty),
                        32'(out_data.irq_send_empty));
          compare_field("irq_recv_nonempty", 32'(want.irq_recv_nonempty),
                        32'(out_data.irq_recv_nonempty));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(mailbox_access(in_data));
      results_outstanding <= expected_results.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import dcis_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        results_outstanding;

  // Idle rates in percent, changed between phases by the stimulus process
  int send_idle = 23;
  int recv_idle = 86;

  // Long receiver hold-off request, picked up by the receiver process
  bit hold_req = 1'b0;

  // Burst state of the random generator
  int         burst_left = 0;
  logic [2:0] burst_op   = OP_SEND;
  bit         burst_side = 1'b0;

  dual_cpu_ipc_sync_fifo_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ipc_mailbox_checker mailbox_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data),
    .fail_count          (fail_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: drop out_ready at the current idle rate, or hold it low for a
  // long stretch on request so the block backs up and stalls its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic in_item_t access_item(logic [2:0] op, bit sd, logic [31:0] wd,
                                           logic [15:0] wm);
    in_item_t a;
    a.opcode     = op;
    a.side       = sd;
    a.write_data = wd;
    a.write_mask = wm;
    return a;
  endfunction

  // Offer one item, idling before it at the current rate, and hold it until
  // the block takes it. Valid stays high on return so back-to-back items
  // never lower and raise it in the same step.
  task automatic drive_access(in_item_t a);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_outstanding != 0);
  endtask

  // Random access: mostly sends and receives, with bursts from one side that
  // run FIFOs full or empty so overflow and underflow show up regularly.
  function automatic in_item_t random_access();
    in_item_t a;
    int       pick;
    a.side       = 1'($urandom_range(1));
    a.write_data = $urandom;
    a.write_mask = ($urandom_range(9) < 6) ? 16'hFFFF : 16'($urandom);
    if (burst_left == 0 && $urandom_range(19) == 0) begin
      burst_left = $urandom_range(6, 20);
      burst_op   = $urandom_range(1) ? OP_SEND : OP_RD_RECV;
      burst_side = 1'($urandom_range(1));
    end
    if (burst_left > 0) begin
      burst_left--;
      a.opcode = burst_op;
      a.side   = burst_side;
      return a;
    end
    pick = $urandom_range(99);
    if (pick < 30)      a.opcode = OP_SEND;
    else if (pick < 55) a.opcode = OP_RD_RECV;
    else if (pick < 67) a.opcode = OP_WR_CTRL;
    else if (pick < 77) a.opcode = OP_WR_SYNC;
    else if (pick < 87) a.opcode = OP_RD_SYNC;
    else if (pick < 97) a.opcode = OP_RD_CTRL;
    else                a.opcode = $urandom_range(1) ? OP_RSVD0 : OP_RSVD1;
    // Keep the FIFOs mostly enabled and clear them only now and then.
    if (a.opcode == OP_WR_CTRL) begin
      a.write_data[CTRL_FEN_BIT]   = ($urandom_range(9) != 0);
      a.write_data[CTRL_CLEAR_BIT] = ($urandom_range(11) == 0);
    end
    return a;
  endfunction

  initial begin
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: register defaults, both interrupt edges, underflow and its
    // acknowledge, receive while disabled, sync request, unused codes,
    // overflow, FIFO clear and send while disabled.
    drive_access(access_item(OP_RD_SYNC, 1'b0, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_RD_CTRL, 1'b1, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_WR_CTRL, 1'b0, 32'h0000_8404, 16'hFFFF));
    drive_access(access_item(OP_WR_CTRL, 1'b1, 32'h0000_8400, 16'hFFFF));
    drive_access(access_item(OP_RD_RECV, 1'b1, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_RD_CTRL, 1'b1, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_WR_CTRL, 1'b1, 32'h0000_4000, 16'h0000));
    drive_access(access_item(OP_SEND,    1'b0, 32'hFFFF_FFFF, 16'h0000));
    drive_access(access_item(OP_SEND,    1'b0, 32'h0000_0000, 16'hFFFF));
    drive_access(access_item(OP_WR_CTRL, 1'b1, 32'h0000_0000, 16'h8400));
    drive_access(access_item(OP_RD_RECV, 1'b1, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_WR_CTRL, 1'b1, 32'h0000_8400, 16'h8400));
    drive_access(access_item(OP_RD_RECV, 1'b1, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_RD_RECV, 1'b1, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_WR_SYNC, 1'b1, 32'h0000_4F00, 16'hFFFF));
    drive_access(access_item(OP_WR_SYNC, 1'b0, 32'hFFFF_2A00, 16'hFFFF));
    drive_access(access_item(OP_WR_SYNC, 1'b0, 32'h0000_2000, 16'hDFFF));
    drive_access(access_item(OP_RD_SYNC, 1'b1, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_RSVD0,   1'b0, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_RSVD1,   1'b1, 32'hFFFF_FFFF, 16'hFFFF));
    // Seventeen sends into a sixteen-entry FIFO: the last one overflows.
    for (int k = 0; k < 17; k++)
      drive_access(access_item(OP_SEND, 1'b1, 32'hA5A5_0000 + k, 16'hFFFF));
    drive_access(access_item(OP_RD_CTRL, 1'b1, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_RD_CTRL, 1'b0, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_WR_CTRL, 1'b1, 32'h0000_800C, 16'hFFFF));
    drive_access(access_item(OP_WR_CTRL, 1'b1, 32'h0000_0000, 16'h8000));
    drive_access(access_item(OP_SEND,    1'b1, 32'h1234_5678, 16'hFFFF));
    drive_access(access_item(OP_RD_CTRL, 1'b0, 32'h0000_0000, 16'h0000));
    drive_access(access_item(OP_WR_CTRL, 1'b1, 32'h0000_8000, 16'h8000));

    // Random, sender mostly busy and receiver mostly stalled.
    for (int k = 0; k < 500; k++) drive_access(random_access());
    wait_drained();

    // Random, rates swapped.
    send_idle = 86;
    recv_idle = 23;
    for (int k = 0; k < 500; k++) drive_access(random_access());
    wait_drained();

    // Random, no idling on either side, with one long receiver hold-off
    // while items keep coming so the block fills and pushes back.
    send_idle = 0;
    recv_idle = 0;
    for (int k = 0; k < 510; k++) begin
      if (k == 200) hold_req = 1'b1;
      drive_access(random_access());
    end
    wait_drained();

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dcis_pkg.sv
design/dcis_ram.sv
design/dcis_ctrl.sv
design/dual_cpu_ipc_sync_fifo_top.sv
bench/ipc_mailbox_checker.sv
bench/testbench.sv
